// ===== design/xtea_ctr_crypt_defines.svh =====
// Assertion macros for the XTEA counter-mode block.
// Used by the top level; no other dependencies.
`ifndef XTEA_CTR_CRYPT_DEFINES_SVH
`define XTEA_CTR_CRYPT_DEFINES_SVH

`ifndef SYNTHESIS
// Check a condition in the cycle after a trigger.
`define XCC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");
// Check a condition in the same cycle as a trigger.
`define XCC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");
`else
`define XCC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`define XCC_ASSERT_NOW(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== design/xcc_pkg.sv =====
// Shared types, constants and stage-constant functions for the XTEA CTR block.
// No dependencies.
package xcc_pkg;

   localparam int ROUNDS      = 32;
   localparam int HALF_STAGES = 2 * ROUNDS;
   localparam int WORD_WIDTH  = 32;
   localparam int DATA_WIDTH  = 64;
   localparam int KEY_WORDS   = 4;
   localparam int CSR_INDEX_WIDTH = 3;

   localparam logic [WORD_WIDTH-1:0] XTEA_DELTA = 32'h9E37_79B9;

   // Register index codes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_WORD_0 = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_WORD_1 = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_WORD_2 = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_WORD_3 = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IV_HIGH    = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IV_LOW     = 3'd5;

   // One pipeline slot: the two cipher halves in flight plus the data to mask
   typedef struct packed {
      logic                  valid;
      logic [DATA_WIDTH-1:0] data;
      logic [WORD_WIDTH-1:0] a;
      logic [WORD_WIDTH-1:0] b;
   } stage_type;

   // Running sum seen by half-round j: even halves use the sum before the
   // delta step, odd halves the sum after it.
   function automatic logic [WORD_WIDTH-1:0] stage_sum(input int j);
      logic [WORD_WIDTH-1:0] steps;
      steps = WORD_WIDTH'((j >> 1) + (j & 1));
      return steps * XTEA_DELTA;
   endfunction

   // Key word index used by half-round j
   function automatic logic [1:0] key_select(input int j);
      logic [WORD_WIDTH-1:0] s;
      s = stage_sum(j);
      return ((j & 1) == 0) ? s[1:0] : s[12:11];
   endfunction

endpackage

// ===== design/xcc_cell.sv =====
// One XTEA half-round cell: updates one half and swaps the pair onwards.
// Depends on xcc_pkg.
module xcc_cell (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               enable,
   input  logic [xcc_pkg::WORD_WIDTH-1:0]     stage_sum,
   input  logic [xcc_pkg::WORD_WIDTH-1:0]     key_word,
   input  xcc_pkg::stage_type                 stage_in,
   output xcc_pkg::stage_type                 stage_out
);
   import xcc_pkg::*;

   logic                  valid_ff, valid_in;
   logic [DATA_WIDTH-1:0] data_ff;
   logic [WORD_WIDTH-1:0] a_ff, b_ff;
   logic [WORD_WIDTH-1:0] mix_word, round_key, b_in;

   // Mix the other half and add the round key, in parallel
   always_comb begin
      mix_word  = ((stage_in.b << 4) ^ (stage_in.b >> 5)) + stage_in.b;
      round_key = stage_sum + key_word;
      b_in      = stage_in.a + (mix_word ^ round_key);
      valid_in  = stage_in.valid;
   end

   // Clear the valid flag under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   // Advance the payload; the halves swap so the next cell updates the other one
   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= stage_in.data;
         a_ff    <= stage_in.b;
         b_ff    <= b_in;
      end
   end

   assign stage_out = '{valid: valid_ff, data: data_ff, a: a_ff, b: b_ff};

endmodule

// ===== design/xcc_ingress.sv =====
// Configuration registers, block counter and the first pipeline slot.
// Depends on xcc_pkg.
module xcc_ingress (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       enable,
   input  logic                                       csr_write_enable,
   input  logic [xcc_pkg::CSR_INDEX_WIDTH-1:0]        csr_index,
   input  logic [xcc_pkg::WORD_WIDTH-1:0]             csr_write_data,
   input  logic                                       req_valid,
   input  logic [xcc_pkg::DATA_WIDTH-1:0]             req_data_block,
   input  logic                                       req_new_message,
   output logic [xcc_pkg::KEY_WORDS-1:0][xcc_pkg::WORD_WIDTH-1:0] key_words,
   output xcc_pkg::stage_type                         stage_out
);
   import xcc_pkg::*;

   logic [KEY_WORDS-1:0][WORD_WIDTH-1:0] key_ff;
   logic [WORD_WIDTH-1:0] iv_high_ff, iv_low_ff;
   logic [DATA_WIDTH-1:0] counter_ff, counter_in;
   logic [DATA_WIDTH-1:0] block_ctr;
   logic                  accept;
   logic                  valid_ff;
   logic [DATA_WIDTH-1:0] data_ff, ctr_ff;

   // Decode register writes; indexes past the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff     <= '0;
         iv_high_ff <= '0;
         iv_low_ff  <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_KEY_WORD_0: key_ff[0]  <= csr_write_data;
            CSR_KEY_WORD_1: key_ff[1]  <= csr_write_data;
            CSR_KEY_WORD_2: key_ff[2]  <= csr_write_data;
            CSR_KEY_WORD_3: key_ff[3]  <= csr_write_data;
            CSR_IV_HIGH:    iv_high_ff <= csr_write_data;
            CSR_IV_LOW:     iv_low_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Pick the counter for this block, reloading from the IV on a new message
   always_comb begin
      accept     = req_valid && enable;
      block_ctr  = req_new_message ? {iv_high_ff, iv_low_ff} : counter_ff;
      counter_in = block_ctr + DATA_WIDTH'(1);
   end

   // Advance the counter once per accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= '0;
      end else if (accept) begin
         counter_ff <= counter_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= req_valid;
      end
   end

   // Load the payload only on acceptance so it always holds the latest block
   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= req_data_block;
         ctr_ff  <= block_ctr;
      end
   end

   assign key_words = key_ff;
   assign stage_out = '{valid: valid_ff, data: data_ff,
                        a: ctr_ff[DATA_WIDTH-1:WORD_WIDTH], b: ctr_ff[WORD_WIDTH-1:0]};

endmodule

// ===== design/xtea_ctr_crypt.sv =====
// XTEA counter-mode cipher: one 64-bit block per cycle while the result is not stalled, fully pipelined.
// From acceptance a block passes the ingress slot, one cell per half-round, then the output register.
// Throughput: one transaction per cycle; a stalled result freezes the whole chain.
// Reset (synchronous): clears valid flags, key, IV and counter to zero.
// Depends on xcc_pkg, xcc_ingress, xcc_cell and xtea_ctr_crypt_defines.svh.
`include "xtea_ctr_crypt_defines.svh"

module xtea_ctr_crypt (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [xcc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [xcc_pkg::WORD_WIDTH-1:0]      csr_write_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [xcc_pkg::DATA_WIDTH-1:0]      req_data_block,
   input  logic                                req_new_message,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [xcc_pkg::DATA_WIDTH-1:0]      rsp_result_block
);
   import xcc_pkg::*;

   logic enable;
   logic [KEY_WORDS-1:0][WORD_WIDTH-1:0] key_words;
   stage_type chain [HALF_STAGES+1];
   logic                  rsp_valid_ff;
   logic [DATA_WIDTH-1:0] rsp_result_ff, rsp_result_in;
   logic [DATA_WIDTH-1:0] first_ctr;

   // Move the chain unless a finished result is waiting to be taken
   assign enable    = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !enable;

   xcc_ingress u_ingress (
      .clock            (clock),
      .reset            (reset),
      .enable           (enable),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_data_block   (req_data_block),
      .req_new_message  (req_new_message),
      .key_words        (key_words),
      .stage_out        (chain[0])
   );

   // Row of half-round cells with per-position sum and key choice
   for (genvar j = 0; j < HALF_STAGES; j++) begin : g_cell
      localparam logic [WORD_WIDTH-1:0] SUM     = stage_sum(j);
      localparam logic [1:0]            KEY_SEL = key_select(j);

      xcc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .stage_sum (SUM),
         .key_word  (key_words[KEY_SEL]),
         .stage_in  (chain[j]),
         .stage_out (chain[j+1])
      );
   end

   // Mask the data with the keystream into the output register
   assign rsp_result_in = chain[HALF_STAGES].data
                          ^ {chain[HALF_STAGES].a, chain[HALF_STAGES].b};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= chain[HALF_STAGES].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rsp_result_ff <= rsp_result_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_block = rsp_result_ff;

   assign first_ctr = {chain[0].a, chain[0].b};

   // Accepted data lands in the first slot
   `XCC_ASSERT_NEXT(a_ingress_load, clock, reset, req_valid && !req_stall,
      chain[0].valid && chain[0].data == $past(req_data_block))
   // Back-to-back blocks of one message use consecutive counters
   `XCC_ASSERT_NEXT(a_counter_step, clock, reset,
      req_valid && !req_stall && !req_new_message && chain[0].valid,
      first_ctr == $past(first_ctr) + DATA_WIDTH'(1))
   // A stalled result freezes the tail of the chain
   `XCC_ASSERT_NEXT(a_chain_hold, clock, reset, rsp_valid && rsp_stall,
      $stable(chain[HALF_STAGES].valid) && $stable(chain[HALF_STAGES].b))

endmodule

// ===== tb/sv/xtea_ctr_crypt_tb.sv =====
// Self-checking testbench for the XTEA counter-mode block xtea_ctr_crypt.
// Needs xcc_pkg for port widths and register index codes; reads no files.
`timescale 1ns / 1ps

module xtea_ctr_crypt_tb;
   import xcc_pkg::*;

   localparam int CLK_PERIOD   = 20;
   localparam int RESET_CYCLES = 6;
   localparam int MAX_IDLE     = 14;
   localparam int DRAIN_CYCLES = 2 * ROUNDS + 2 + 16;
   localparam int HOLD_CYCLES  = 300;
   localparam longint LIMIT_NS = 64'd20_000_000;

   // Indexes beyond the last register; writes to them must be ignored
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_7 = 3'd7;

   localparam logic [WORD_WIDTH-1:0] WORD_ZERO = '0;
   localparam logic [WORD_WIDTH-1:0] WORD_ONES = '1;
   localparam logic [DATA_WIDTH-1:0] BLOCK_ZERO = '0;
   localparam logic [DATA_WIDTH-1:0] BLOCK_ONES = '1;

   logic                       clock;
   logic                       reset;
   logic                       csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [WORD_WIDTH-1:0]      csr_write_data;
   logic                       req_valid;
   logic                       req_stall;
   logic [DATA_WIDTH-1:0]      req_data_block;
   logic                       req_new_message;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic [DATA_WIDTH-1:0]      rsp_result_block;

   // Mirror of the block's registers and running counter
   logic [WORD_WIDTH-1:0] key_reg [KEY_WORDS];
   logic [WORD_WIDTH-1:0] iv_high_reg;
   logic [WORD_WIDTH-1:0] iv_low_reg;
   logic [DATA_WIDTH-1:0] block_counter;

   logic [DATA_WIDTH-1:0] expected_blocks [$];
   logic [DATA_WIDTH-1:0] expected_block;
   int                    error_count;

   // Idling controls shared between the test tasks and the two sides
   bit tx_idle;
   bit rx_idle;
   int hold_off_request;

   xtea_ctr_crypt dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_block   (req_data_block),
      .req_new_message  (req_new_message),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_block (rsp_result_block)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(LIMIT_NS);
      $display("xtea_ctr_crypt_tb: errors");
      $finish;
   end

   // XTEA encipherment of one counter value under the mirrored key
   function automatic logic [DATA_WIDTH-1:0] xtea_keystream(input logic [DATA_WIDTH-1:0] ctr);
      logic [WORD_WIDTH-1:0] v0;
      logic [WORD_WIDTH-1:0] v1;
      logic [WORD_WIDTH-1:0] sum;
      v0  = ctr[63:32];
      v1  = ctr[31:0];
      sum = '0;
      for (int r = 0; r < ROUNDS; r++) begin
         v0  = v0 + ((((v1 << 4) ^ (v1 >> 5)) + v1) ^ (sum + key_reg[sum[1:0]]));
         sum = sum + XTEA_DELTA;
         v1  = v1 + ((((v0 << 4) ^ (v0 >> 5)) + v0) ^ (sum + key_reg[sum[12:11]]));
      end
      return {v0, v1};
   endfunction

   // Mask one data block and advance the counter, reloading it first on a new message
   function automatic logic [DATA_WIDTH-1:0] cipher_block(input logic [DATA_WIDTH-1:0] data,
                                                          input logic new_msg);
      logic [DATA_WIDTH-1:0] masked;
      if (new_msg)
         block_counter = {iv_high_reg, iv_low_reg};
      masked        = data ^ xtea_keystream(block_counter);
      block_counter = block_counter + DATA_WIDTH'(1);
      return masked;
   endfunction

   function automatic logic [DATA_WIDTH-1:0] pick_data();
      case ($urandom_range(0, 15))
         0:       return BLOCK_ZERO;
         1:       return BLOCK_ONES;
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   function automatic logic [WORD_WIDTH-1:0] pick_word();
      case ($urandom_range(0, 7))
         0:       return WORD_ZERO;
         1:       return WORD_ONES;
         default: return $urandom();
      endcase
   endfunction

   // Write one register and update the mirror; only called while the block is idle
   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [WORD_WIDTH-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_KEY_WORD_0: key_reg[0]  = value;
         CSR_KEY_WORD_1: key_reg[1]  = value;
         CSR_KEY_WORD_2: key_reg[2]  = value;
         CSR_KEY_WORD_3: key_reg[3]  = value;
         CSR_IV_HIGH:    iv_high_reg = value;
         CSR_IV_LOW:     iv_low_reg  = value;
         default: ;
      endcase
   endtask

   task automatic load_settings(input logic [WORD_WIDTH-1:0] k0, input logic [WORD_WIDTH-1:0] k1,
                                input logic [WORD_WIDTH-1:0] k2, input logic [WORD_WIDTH-1:0] k3,
                                input logic [WORD_WIDTH-1:0] ivh, input logic [WORD_WIDTH-1:0] ivl);
      write_csr(CSR_KEY_WORD_0, k0);
      write_csr(CSR_KEY_WORD_1, k1);
      write_csr(CSR_KEY_WORD_2, k2);
      write_csr(CSR_KEY_WORD_3, k3);
      write_csr(CSR_IV_HIGH, ivh);
      write_csr(CSR_IV_LOW, ivl);
   endtask

   // Offer one transaction, after a random gap when tx_idle is set, and hold it until accepted
   task automatic send_block(input logic [DATA_WIDTH-1:0] data, input logic new_msg);
      int gap;
      gap = tx_idle ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_data_block  <= data;
      req_new_message <= new_msg;
      do @(posedge clock); while (req_stall);
      expected_blocks.push_back(cipher_block(data, new_msg));
   endtask

   // Drop valid and wait for every outstanding result
   task automatic pause_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_blocks.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // No message started yet: the counter runs on from zero under the reset key
   task automatic test_reset_counter();
      send_block(BLOCK_ZERO, 1'b0);
      send_block(BLOCK_ONES, 1'b0);
      send_block(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
      send_block(64'h5555_5555_5555_5555, 1'b0);
      pause_until_drained();
   endtask

   // Key and IV at their extremes, data at its extremes, reload on and off
   task automatic test_key_extremes();
      load_settings(WORD_ONES, WORD_ONES, WORD_ONES, WORD_ONES, WORD_ONES, WORD_ONES);
      send_block(BLOCK_ZERO, 1'b1);
      send_block(BLOCK_ONES, 1'b0);
      send_block(BLOCK_ZERO, 1'b0);
      pause_until_drained();
      load_settings(32'hAAAA_AAAA, 32'h5555_5555, WORD_ZERO, WORD_ONES, WORD_ZERO, WORD_ZERO);
      send_block(BLOCK_ONES, 1'b0);
      send_block(BLOCK_ZERO, 1'b1);
      send_block(BLOCK_ONES, 1'b1);
      send_block(64'h0123_4567_89AB_CDEF, 1'b0);
      pause_until_drained();
   endtask

   // Counter carries across the word boundary and wraps from all ones to zero
   task automatic test_counter_wrap();
      load_settings($urandom(), $urandom(), $urandom(), $urandom(), WORD_ZERO, WORD_ONES);
      send_block(pick_data(), 1'b1);
      send_block(pick_data(), 1'b0);
      pause_until_drained();
      write_csr(CSR_IV_HIGH, WORD_ONES);
      write_csr(CSR_IV_LOW, 32'hFFFF_FFFE);
      send_block(pick_data(), 1'b1);
      send_block(pick_data(), 1'b0);
      send_block(pick_data(), 1'b0);
      send_block(pick_data(), 1'b0);
      pause_until_drained();
   endtask

   // Writes above the last index leave key and IV untouched
   task automatic test_unused_index();
      write_csr(CSR_SPARE_6, $urandom());
      write_csr(CSR_SPARE_7, WORD_ONES);
      send_block(pick_data(), 1'b1);
      send_block(pick_data(), 1'b0);
      pause_until_drained();
      write_csr(CSR_SPARE_6, WORD_ONES);
      send_block(pick_data(), 1'b1);
      pause_until_drained();
   endtask

   // Phases of random messages, each under a fresh key and IV
   task automatic test_random_traffic();
      logic nm;
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: load_settings(WORD_ZERO, WORD_ZERO, WORD_ZERO, WORD_ZERO, WORD_ZERO, WORD_ZERO);
            1: load_settings(WORD_ONES, WORD_ONES, WORD_ONES, WORD_ONES,
                             WORD_ONES, $urandom_range(32'hFFFF_FFC0, 32'hFFFF_FFFF));
            default: load_settings(pick_word(), pick_word(), pick_word(), pick_word(),
                                   pick_word(), pick_word());
         endcase
         for (int i = 0; i < 80; i++) begin
            // reshuffle idling every so often, leaving some stretches without it
            if (i % 20 == 0) begin
               tx_idle = ($urandom_range(0, 2) != 0);
               rx_idle = ($urandom_range(0, 2) != 0);
            end
            nm = (i == 0) ? (phase != 0) : ($urandom_range(0, 11) == 0);
            send_block(pick_data(), nm);
         end
         pause_until_drained();
      end
      tx_idle = 1'b1;
      rx_idle = 1'b1;
   endtask

   // Receiver holds off for a long stretch while the sender streams flat out
   task automatic test_backpressure();
      tx_idle          = 1'b0;
      hold_off_request = HOLD_CYCLES;
      send_block(pick_data(), 1'b1);
      for (int i = 1; i < 150; i++)
         send_block(pick_data(), $urandom_range(0, 31) == 0);
      tx_idle = 1'b1;
      pause_until_drained();
   endtask

   // Sender waits for every result in the middle of a message, then carries on
   task automatic test_drain_pause();
      send_block(pick_data(), 1'b1);
      for (int i = 1; i < 20; i++)
         send_block(pick_data(), 1'b0);
      pause_until_drained();
      for (int i = 0; i < 20; i++)
         send_block(pick_data(), 1'b0);
      pause_until_drained();
   endtask

   // Receiver: draw a stall length per transaction, or take a requested hold-off
   initial begin
      int stall_len;
      rsp_stall = 1'b0;
      forever begin
         stall_len = rx_idle ? $urandom_range(0, MAX_IDLE) : 0;
         if (hold_off_request > 0) begin
            stall_len        = hold_off_request;
            hold_off_request = 0;
         end
         if (stall_len > 0) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
            repeat (stall_len - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_blocks.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h",
                     $time, rsp_result_block);
            error_count++;
         end else begin
            expected_block = expected_blocks.pop_front();
            if (rsp_result_block !== expected_block) begin
               $display("%0t: result_block mismatch, expected %h, actual %h",
                        $time, expected_block, rsp_result_block);
               error_count++;
            end
         end
      end
   end

   initial begin
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = CSR_KEY_WORD_0;
      csr_write_data   = '0;
      req_valid        = 1'b0;
      req_data_block   = '0;
      req_new_message  = 1'b0;
      error_count      = 0;
      tx_idle          = 1'b1;
      rx_idle          = 1'b1;
      hold_off_request = 0;
      for (int k = 0; k < KEY_WORDS; k++)
         key_reg[k] = '0;
      iv_high_reg   = '0;
      iv_low_reg    = '0;
      block_counter = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_counter();
      test_key_extremes();
      test_counter_wrap();
      test_unused_index();
      test_random_traffic();
      test_backpressure();
      test_drain_pause();

      pause_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_blocks.size() == 0)
         $display("xtea_ctr_crypt_tb: clean");
      else
         $display("xtea_ctr_crypt_tb: errors");
      $finish;
   end

endmodule
